// ----- hdl/siss_pkg.sv -----
// Shared types and constants for the small integer set store.
package siss_pkg;

	// Default store depth
	localparam int unsigned DEPTH_DEF = 16;

	// Payload widths
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;

	// Operation codes; the unused code behaves as a query
	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_QUERY  = 2'd2
	} kind_t;

endpackage

// ----- hdl/siss_ram.sv -----
// Single-port-write, registered-read element store for the set.
module siss_ram import siss_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF,
	parameter int unsigned AW    = 4
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [VALUE_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [VALUE_W-1:0] rd_data
);

	logic [VALUE_W-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read one entry, data valid the next cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/small_integer_set_store.sv -----
// Small integer set store: a set of distinct signed 32-bit values kept in insertion order.
// Each input beat carries an operation (insert, remove, query) and a value, and
// yields one result beat with membership before the operation, success, and the
// count, least and greatest value afterwards (0 and 0 when empty). Work runs in a
// small sequencer over one registered-read memory port: a lookup scan over the N
// held entries, for a remove of a held value a shift of the later entries down one
// place, and an extremes scan over the entries held afterwards, between taking the
// beat and posting the result. The result sits in an output register, so the next
// input beat is taken while the previous result still waits; the post of that next
// result holds until the previous one is taken. A new value inserted into a full
// store is refused with succeeded low.
module small_integer_set_store import siss_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [KIND_W-1:0]         kind,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      was_member,
	output logic                      succeeded,
	output logic [COUNT_W-1:0]        element_count,
	output logic signed [VALUE_W-1:0] smallest,
	output logic signed [VALUE_W-1:0] largest
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FIND  = 5'b00010,
		ST_SHIFT = 5'b00100,
		ST_EXTR  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t                    state_q;
	logic [KIND_W-1:0]         kind_q;
	logic [VALUE_W-1:0]        value_q;
	logic                      found_q;
	logic [AW-1:0]             slot_q;
	logic                      ok_q;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             rd_idx_q;
	logic [AW-1:0]             idx_s1;
	logic                      issue_s1;
	logic                      first_q;
	logic signed [VALUE_W-1:0] lo_q;
	logic signed [VALUE_W-1:0] hi_q;
	logic                      out_valid_q;

	logic                      scan_more;
	logic                      drained;
	logic                      scanning;
	logic                      rd_en;
	logic [VALUE_W-1:0]        rd_data;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [VALUE_W-1:0]        wr_data;
	logic                      is_insert;
	logic                      is_remove;
	logic                      room;
	logic                      add_new;
	logic                      hit;
	logic                      out_free;
	logic signed [VALUE_W-1:0] rd_val;
	logic [31:0]               cnt_wide;

	// Shared scan control
	assign scanning  = (state_q == ST_FIND) || (state_q == ST_SHIFT) || (state_q == ST_EXTR);
	assign scan_more = rd_idx_q < cnt_q;
	assign drained   = !scan_more && !issue_s1;
	assign rd_en     = scanning && scan_more;
	assign rd_val    = $signed(rd_data);
	assign hit       = issue_s1 && (rd_data == value_q);

	// Decode the held operation
	assign is_insert = kind_q == KIND_INSERT;
	assign is_remove = kind_q == KIND_REMOVE;
	assign room      = cnt_q < CW'(DEPTH);
	assign add_new   = (state_q == ST_FIND) && drained && is_insert && !found_q && room;
	assign out_free  = !out_valid_q || out_ready;
	assign cnt_wide  = 32'(cnt_q);

	// Steer the write port: append on insert, move down on remove
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[AW-1:0];
		wr_data = value_q;
		if (add_new) begin
			wr_en = 1'b1;
		end else if ((state_q == ST_SHIFT) && issue_s1) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1 - AW'(1);
			wr_data = rd_data;
		end
	end

	siss_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			issue_s1    <= 1'b0;
			found_q     <= 1'b0;
			ok_q        <= 1'b1;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// Post the result, or drop it once taken
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// Advance the scan address
			issue_s1 <= rd_en;
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						rd_idx_q <= '0;
						found_q  <= 1'b0;
						ok_q     <= 1'b1;
						state_q  <= ST_FIND;
					end
				end
				ST_FIND: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					if (drained) begin
						first_q  <= 1'b1;
						rd_idx_q <= '0;
						state_q  <= ST_EXTR;
						if (is_insert && !found_q) begin
							if (room) begin
								cnt_q <= cnt_q + CW'(1);
							end else begin
								ok_q <= 1'b0;
							end
						end else if (is_remove && found_q) begin
							rd_idx_q <= CW'(slot_q) + CW'(1);
							state_q  <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (drained) begin
						cnt_q    <= cnt_q - CW'(1);
						first_q  <= 1'b1;
						rd_idx_q <= '0;
						state_q  <= ST_EXTR;
					end
				end
				ST_EXTR: begin
					if (issue_s1) begin
						first_q <= 1'b0;
					end
					if (drained) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the beat payload and the matching slot
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_q  <= kind;
			value_q <= value;
		end
		if ((state_q == ST_FIND) && hit) begin
			slot_q <= idx_s1;
		end
		if (rd_en) begin
			idx_s1 <= rd_idx_q[AW-1:0];
		end
	end

	// Track least and greatest value over the extremes scan
	always_ff @(posedge clk) begin
		if ((state_q == ST_FIND) && drained) begin
			lo_q <= '0;
			hi_q <= '0;
		end else if ((state_q == ST_SHIFT) && drained) begin
			lo_q <= '0;
			hi_q <= '0;
		end else if ((state_q == ST_EXTR) && issue_s1) begin
			if (first_q || (rd_val < lo_q)) begin
				lo_q <= rd_val;
			end
			if (first_q || (rd_val > hi_q)) begin
				hi_q <= rd_val;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			was_member    <= found_q;
			succeeded     <= ok_q;
			element_count <= cnt_wide[COUNT_W-1:0];
			smallest      <= lo_q;
			largest       <= hi_q;
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

// ----- hdl/siss_checker.sv -----
// Port-level checks for the small integer set store, bound to the top level.
module siss_checker import siss_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               was_member,
	input logic               succeeded,
	input logic [4:0]         element_count,
	input logic signed [31:0] smallest,
	input logic signed [31:0] largest
);

	// One operation at a time: no beat taken right after another
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken twice in a row");

	// Empty set reports zero extremes
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (element_count == 5'd0)) |-> ((smallest == 0) && (largest == 0)))
		else $error("empty set with nonzero extremes");

	// Extremes are ordered
	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (smallest <= largest))
		else $error("smallest above largest");

	// A refused insert means a new value met a full store
	a_refused_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !succeeded) |-> (!was_member && (element_count == 5'(DEPTH))))
		else $error("refusal without a full store");

	// A pending result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(element_count)))
		else $error("result dropped before taken");

endmodule

bind small_integer_set_store siss_checker #(.DEPTH(DEPTH)) u_siss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.was_member    (was_member),
	.succeeded     (succeeded),
	.element_count (element_count),
	.smallest      (smallest),
	.largest       (largest)
);

// ----- dv/tb_small_integer_set_store.sv -----
// Self-checking testbench for the small integer set store: scoreboard class and top module.
import siss_pkg::*;

// One result beat as the block reports it
typedef struct {
	logic                      was_member;
	logic                      succeeded;
	logic [COUNT_W-1:0]        count;
	logic signed [VALUE_W-1:0] lo;
	logic signed [VALUE_W-1:0] hi;
} set_result_t;

// Mirror of the held set plus the queue of results still owed by the block
class set_scoreboard;
	int unsigned               depth;
	logic signed [VALUE_W-1:0] members[$];
	set_result_t               owed[$];
	int unsigned               mismatches;
	int unsigned               n_ops;
	int unsigned               n_refused;
	int unsigned               n_removed;
	int unsigned               n_empty;
	int unsigned               peak;

	function new(int unsigned d);
		depth = d;
	endfunction

	// Apply one accepted operation to the mirror and queue its result
	function void note_op(logic [KIND_W-1:0] k, logic signed [VALUE_W-1:0] v);
		int          slot;
		set_result_t res;
		slot = -1;
		foreach (members[i]) begin
			if (slot < 0 && members[i] == v)
				slot = i;
		end
		res.was_member = (slot >= 0);
		res.succeeded  = 1'b1;
		case (k)
			KIND_INSERT: begin
				if (slot < 0) begin
					if (members.size() < depth) begin
						members.push_back(v);
					end else begin
						res.succeeded = 1'b0;
						n_refused++;
					end
				end
			end
			KIND_REMOVE: begin
				if (slot >= 0) begin
					members.delete(slot);
					n_removed++;
				end
			end
			default: ;
		endcase
		// Extremes over what is held afterwards, 0 and 0 when empty
		res.lo = '0;
		res.hi = '0;
		foreach (members[i]) begin
			if (i == 0 || members[i] < res.lo)
				res.lo = members[i];
			if (i == 0 || members[i] > res.hi)
				res.hi = members[i];
		end
		res.count = COUNT_W'(members.size());
		if (members.size() == 0)
			n_empty++;
		if (members.size() > peak)
			peak = members.size();
		n_ops++;
		owed.push_back(res);
	endfunction

	// Compare one result beat against the oldest owed result
	function void check_result(set_result_t got);
		set_result_t want;
		if (owed.size() == 0) begin
			$error("result beat with no operation outstanding");
			mismatches++;
			return;
		end
		want = owed.pop_front();
		if (got.was_member !== want.was_member) begin
			$error("was_member: expected %0d, got %0d", want.was_member, got.was_member);
			mismatches++;
		end
		if (got.succeeded !== want.succeeded) begin
			$error("succeeded: expected %0d, got %0d", want.succeeded, got.succeeded);
			mismatches++;
		end
		if (got.count !== want.count) begin
			$error("element_count: expected %0d, got %0d", want.count, got.count);
			mismatches++;
		end
		if (got.lo !== want.lo) begin
			$error("smallest: expected %0d, got %0d", want.lo, got.lo);
			mismatches++;
		end
		if (got.hi !== want.hi) begin
			$error("largest: expected %0d, got %0d", want.hi, got.hi);
			mismatches++;
		end
	endfunction
endclass

module tb_small_integer_set_store;

	localparam logic [KIND_W-1:0]         KIND_SPARE  = 2'd3;
	localparam logic signed [VALUE_W-1:0] VAL_MIN     = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX     = 32'sh7fff_ffff;
	localparam int unsigned               RAND_OPS    = 1800;
	localparam int unsigned               QUIET_OPS   = 300;
	localparam int unsigned               PHASE_OPS   = 60;
	localparam int unsigned               POOL_N      = 24;
	localparam int unsigned               DRAIN_WAIT  = 2 * DEPTH_DEF + 16;
	localparam int unsigned               CYCLE_LIMIT = 1000000;

	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} op_mix_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [KIND_W-1:0]         kind;
	logic signed [VALUE_W-1:0] value;
	logic                      out_valid;
	logic                      out_ready;
	logic                      was_member;
	logic                      succeeded;
	logic [COUNT_W-1:0]        element_count;
	logic signed [VALUE_W-1:0] smallest;
	logic signed [VALUE_W-1:0] largest;

	set_scoreboard             sb;
	logic                      idle_on;
	int unsigned               cycles = 0;
	logic signed [VALUE_W-1:0] pool[POOL_N];

	small_integer_set_store #(
		.DEPTH(DEPTH_DEF)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.was_member   (was_member),
		.succeeded    (succeeded),
		.element_count(element_count),
		.smallest     (smallest),
		.largest      (largest)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_small_integer_set_store: errors");
			$finish;
		end
	end

	// Offer one operation beat, with an optional idle burst first, and hold it until taken
	task automatic apply_set_op(input logic [KIND_W-1:0] k, input logic signed [VALUE_W-1:0] v);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_op(k, v);
	endtask

	// Choose an operation, weighted by the current mix
	function automatic logic [KIND_W-1:0] pick_kind(op_mix_t mix);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return KIND_SPARE;
		case (mix)
			MIX_FILL:  return (roll < 75) ? KIND_INSERT : (roll < 88) ? KIND_QUERY : KIND_REMOVE;
			MIX_DRAIN: return (roll < 75) ? KIND_REMOVE : (roll < 88) ? KIND_QUERY : KIND_INSERT;
			default:   return (roll < 40) ? KIND_INSERT : (roll < 70) ? KIND_REMOVE : KIND_QUERY;
		endcase
	endfunction

	// Accept and check result beats; stall in random bursts
	initial begin : result_side
		set_result_t got;
		int unsigned stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.was_member = was_member;
				got.succeeded  = succeeded;
				got.count      = element_count;
				got.lo         = smallest;
				got.hi         = largest;
				sb.check_result(got);
			end
			if (stall_left > 0 && idle_on) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				out_ready <= 1'b0;
			end else begin
				stall_left = 0;
				out_ready <= 1'b1;
			end
		end
	end

	// Reset, directed operations, random phases, drain and verdict
	initial begin : op_side
		op_mix_t                   mix;
		logic [KIND_W-1:0]         k;
		logic signed [VALUE_W-1:0] v;
		int unsigned               n;
		sb       = new(DEPTH_DEF);
		idle_on  = 1'b0;
		arst_n   = 1'b0;
		in_valid <= 1'b0;
		kind     <= KIND_QUERY;
		value    <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty query, fill with extremes, full store, duplicates, removes
		idle_on = 1'b1;
		apply_set_op(KIND_QUERY, 32'sd0);
		apply_set_op(KIND_INSERT, VAL_MIN);
		apply_set_op(KIND_INSERT, VAL_MAX);
		apply_set_op(KIND_INSERT, 32'sd0);
		apply_set_op(KIND_INSERT, -32'sd1);
		for (int i = 1; i <= DEPTH_DEF - 4; i++)
			apply_set_op(KIND_INSERT, i);
		apply_set_op(KIND_INSERT, VAL_MIN);
		apply_set_op(KIND_INSERT, 32'sd99);
		apply_set_op(KIND_QUERY, VAL_MAX);
		apply_set_op(KIND_SPARE, -32'sd1);
		apply_set_op(KIND_REMOVE, 32'sd12345);
		apply_set_op(KIND_REMOVE, 32'sd0);
		apply_set_op(KIND_REMOVE, VAL_MIN);
		apply_set_op(KIND_REMOVE, VAL_MAX);

		// Seed the value pool: mostly random words, a few extremes and small numbers
		foreach (pool[i])
			pool[i] = $urandom();
		pool[0] = VAL_MIN;
		pool[1] = VAL_MAX;
		pool[2] = 32'sd0;
		pool[3] = -32'sd1;

		// Random phases: a small pool keeps hits, duplicates and full stores frequent
		mix = MIX_FILL;
		for (n = 0; n < RAND_OPS; n++) begin
			if (n % PHASE_OPS == 0) begin
				mix = op_mix_t'($urandom_range(0, 2));
				idle_on = (n < RAND_OPS - QUIET_OPS) && ($urandom_range(0, 3) != 0);
				for (int j = 0; j < 3; j++)
					pool[$urandom_range(4, POOL_N - 1)] = $urandom();
			end
			k = pick_kind(mix);
			if ($urandom_range(0, 9) == 0)
				v = $urandom();
			else if (k == KIND_REMOVE && sb.members.size() > 0 && $urandom_range(0, 1) == 1)
				v = sb.members[$urandom_range(0, sb.members.size() - 1)];
			else
				v = pool[$urandom_range(0, POOL_N - 1)];
			apply_set_op(k, v);
		end
		in_valid <= 1'b0;

		// Wait out owed results, then a settling window for stray beats
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d operations: %0d refused inserts on a full store, %0d removes of held values.",
			sb.n_ops, sb.n_refused, sb.n_removed);
		$display("Set reached %0d entries at most and was empty after %0d operations.",
			sb.peak, sb.n_empty);
		if (sb.mismatches == 0) begin
			$display("tb_small_integer_set_store: clean");
		end else begin
			$display("tb_small_integer_set_store: errors");
		end
		$finish;
	end

endmodule
